@@ rtl/mmg_pkg.sv @@
// Package for the motor mode guard with fault log.
// Holds the log sizing constants, the operation codes and the shared structs.
// No dependencies.
package mmg_pkg;

  localparam int LOG_DEPTH = 4;
  localparam int FILL_W    = $clog2(LOG_DEPTH + 1);
  localparam int SAT_W     = (FILL_W > 3) ? FILL_W : 3;
  localparam int LOG_SHOWN = (LOG_DEPTH < 4) ? LOG_DEPTH : 4;

  localparam logic [1:0] OP_MODE  = 2'd0;
  localparam logic [1:0] OP_FAULT = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] target_mode;
    logic [7:0] fault_code;
  } mmg_in_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  current_mode;
    logic [31:0] fault_log;
    logic [2:0]  fault_count;
  } mmg_out_t;

  // Passed from one log cell to the next.
  typedef struct packed {
    logic seek;
    logic placed;
  } mmg_link_t;

  // Status from the mode controller to the top level.
  typedef struct packed {
    logic accept;
    logic clear;
  } mmg_mode_stat_t;

endpackage

@@ rtl/motor_mode_guard_with_fault_log.sv @@
// Top level of the motor mode guard with fault log.
// Depends on mmg_pkg, mmg_mode_ctrl and mmg_log_cell.
module motor_mode_guard_with_fault_log (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  mmg_pkg::mmg_in_t in_item,
  output logic             out_valid,
  output mmg_pkg::mmg_out_t out_item
);
  // Each transaction is accepted whenever start is high, since busy never rises,
  // and its result is strobed by out_valid in the following cycle. The fault
  // code ripples combinationally through a chain of log cells; each cell
  // compares against its own slot and the first empty cell still searching
  // stores the code. The receiver cannot stall, so results must be captured on
  // the cycle out_valid is high.
  import mmg_pkg::*;

  logic                go;
  mmg_mode_stat_t      stat;
  logic [2:0]          mode;
  mmg_link_t           links [LOG_DEPTH+1];
  logic [7:0]          slots [LOG_DEPTH];
  logic [FILL_W-1:0]   fill_r;
  logic [SAT_W-1:0]    fill_wide;
  logic                acc_r;
  logic                out_valid_r;
  logic [31:0]         log_packed;

  assign go   = start;
  assign busy = 1'b0;

  mmg_mode_ctrl u_mode (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_item),
    .stat  (stat),
    .mode  (mode)
  );

  assign links[0].seek   = go && (in_item.op == OP_FAULT);
  assign links[0].placed = 1'b0;

  for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
    mmg_log_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (stat.clear),
      .code_in  (in_item.fault_code),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .slot     (slots[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= go;
      acc_r       <= stat.accept || links[LOG_DEPTH].placed;
      if (stat.clear) begin
        fill_r <= '0;
      end else if (links[LOG_DEPTH].placed) begin
        fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

  always_comb begin
    log_packed = 32'd0;
    for (int i = 0; i < LOG_SHOWN; i++) begin
      log_packed[8*i +: 8] = slots[i];
    end
  end

  assign fill_wide = SAT_W'(fill_r);

  always_comb begin
    out_item.accepted     = acc_r;
    out_item.current_mode = mode;
    out_item.fault_log    = log_packed;
    out_item.fault_count  = (fill_wide > SAT_W'(7)) ? 3'd7 : fill_wide[2:0];
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/mmg_log_cell.sv @@
// One slot of the fault log chain.
// Depends on mmg_pkg for the link struct.
module mmg_log_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic [7:0]        code_in,
  input  mmg_pkg::mmg_link_t link_in,
  output mmg_pkg::mmg_link_t link_out,
  output logic [7:0]        slot
);
  import mmg_pkg::*;

  logic       valid_r;
  logic [7:0] slot_r;
  logic       place;
  logic       hit;

  // Filled cells are contiguous from the head, so the first empty cell that
  // still sees a seek has checked every stored code.
  assign place = link_in.seek && !valid_r;
  assign hit   = valid_r && (slot_r == code_in);

  always_comb begin
    link_out.placed = link_in.placed || place;
    link_out.seek   = link_in.seek && valid_r && !hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= 1'b0;
      slot_r  <= 8'd0;
    end else if (place) begin
      valid_r <= 1'b1;
      slot_r  <= code_in;
    end
  end

  assign slot = slot_r;

endmodule

@@ rtl/mmg_mode_ctrl.sv @@
// Mode state machine of the motor mode guard.
// Depends on mmg_pkg for the operation codes and the status struct.
module mmg_mode_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  mmg_pkg::mmg_in_t      item,
  output mmg_pkg::mmg_mode_stat_t stat,
  output logic [2:0]            mode
);
  import mmg_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_HOME   = 3'd1,
    M_RUN    = 3'd2,
    M_STOP   = 3'd3,
    M_ENCCAL = 3'd4,
    M_FNOW   = 3'd5,
    M_FOVER  = 3'd6
  } mode_t;

  mode_t mode_r;
  mode_t mode_nxt;
  mode_t target;
  logic  edge_ok;

  assign target = mode_t'(item.target_mode);

  always_comb begin
    edge_ok = 1'b0;
    if (target == M_FNOW) begin
      edge_ok = 1'b1;
    end else begin
      case (mode_r)
        M_IDLE:   edge_ok = (target == M_HOME) || (target == M_RUN) || (target == M_ENCCAL);
        M_HOME:   edge_ok = (target == M_RUN) || (target == M_STOP);
        M_RUN:    edge_ok = (target == M_STOP);
        M_STOP,
        M_FOVER,
        M_ENCCAL: edge_ok = (target == M_IDLE);
        M_FNOW:   edge_ok = (target == M_FOVER);
        default:  edge_ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    stat.accept = 1'b0;
    stat.clear  = 1'b0;
    if (go) begin
      unique case (item.op)
        OP_MODE: begin
          if (edge_ok) begin
            mode_nxt    = target;
            stat.accept = 1'b1;
          end
        end
        OP_ACK: begin
          if (mode_r == M_FOVER) begin
            mode_nxt    = M_IDLE;
            stat.accept = 1'b1;
            stat.clear  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign mode = mode_r;

endmodule
